### hw/rtl/pffa_pkg.sv
package pffa_pkg;
  localparam int PAGE_BYTES = 4096;
  localparam int STORE_WORDS = PAGE_BYTES / 2;
  localparam int AW = $clog2(STORE_WORDS);
  localparam int PW = $clog2(PAGE_BYTES) + 2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_NOTUSED = 3'd3;
  localparam logic [2:0] ST_BADOFF  = 3'd4;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;
endpackage

### hw/rtl/page_first_fit_allocator_unit.sv
// an invalid request goes straight to the output register; otherwise the unit reads one block header
// per step of a walk, one walk for free, up to three walks (fit, join, fit) for allocate
// throughput: one item at a time, limited by the single page memory port
// reset: synchronous; a clearing pass over all 2048 store words rebuilds the page, inputs not taken
// result held in an output register until transferred
module page_first_fit_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // op, request_bytes, release_offset
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // status, user_offset, bytes_free
);
  localparam int PW = pffa_pkg::PW;
  localparam logic [PW-1:0] PB = PW'(pffa_pkg::PAGE_BYTES);

  localparam logic [3:0] S_IDLE = 4'd0, S_FRD = 4'd1, S_FCHK = 4'd2, S_JRD = 4'd3,
    S_JCHK = 4'd4, S_NRD = 4'd5, S_NCHK = 4'd6, S_SPLIT = 4'd7, S_DONE = 4'd8,
    S_RRD = 4'd9, S_RCHK = 4'd10, S_OUT = 4'd11;

  logic [3:0]    state;
  logic          second;
  logic [PW-1:0] need, pos, nxt, hacc, rel;
  logic [PW-1:0] fcount;
  logic [15:0]   rdata, total;
  logic          busy;
  logic [2:0]    status;
  logic [11:0]   uoff;
  pffa_pkg::mem_req_t req;

  pffa_store u_store (.clk(clk), .rst(rst), .req(req), .rdata(rdata), .busy(busy));

  logic [PW-1:0] h, span, rq, n0;
  always_comb begin
    h = PW'(rdata);
    span = PW'({rdata[15:1], 1'b0}) + PW'(4);
    rq = PW'(s_tdata[13:1]);
    n0 = rq + PW'(rq[0]);
  end

  assign s_tready = (state == S_IDLE) && !busy && !m_tvalid;

  always_comb begin
    req = '0;
    case (state)
      S_FRD, S_JRD, S_RRD: begin
        req.re = 1'b1; req.raddr = pos[pffa_pkg::AW:1];
      end
      S_NRD: begin
        req.re = 1'b1; req.raddr = nxt[pffa_pkg::AW:1];
      end
      S_JCHK: begin
        if (!h[0]) begin
          req.we = 1'b0;
        end
      end
      default: ;
    endcase
    if (state == S_NCHK && !(nxt < PB && !h[0])) begin
      req.we = 1'b1; req.waddr = pos[pffa_pkg::AW:1]; req.wdata = 16'(hacc);
    end
    if (state == S_SPLIT) begin
      req.we = 1'b1; req.waddr = pos[pffa_pkg::AW:1];
      req.wdata = (PW'(total) >= need + PW'(4)) ? 16'(need + 1'b1) : total + 16'd1;
    end
    if (state == S_DONE && PW'(total) >= need + PW'(4)) begin
      req.we = 1'b1; req.waddr = nxt[pffa_pkg::AW:1];
      req.wdata = 16'(PW'(total) - need - PW'(4));
    end
    if (state == S_RCHK && pos == rel - PW'(4) && h[0]) begin
      req.we = 1'b1; req.waddr = pos[pffa_pkg::AW:1]; req.wdata = rdata - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; m_tvalid <= 1'b0; fcount <= PB;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          second <= 1'b0; pos <= '0; uoff <= '0; status <= pffa_pkg::ST_OK;
          rel <= PW'(s_tdata[25:14]);
          if (s_tdata[0]) state <= S_RRD;
          else if (rq == '0 || rq > PB) begin
            status <= pffa_pkg::ST_INVALID; state <= S_OUT;
          end else begin
            need <= (n0 + PW'(4) > PB && (n0 + PW'(4)) % PB > 0 && (n0 + PW'(4)) % PB < 5)
                    ? n0 + PW'(4) : n0;
            state <= S_FRD;
          end
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (!h[0] && h >= need) begin
            total <= rdata; state <= S_SPLIT;
          end else if (pos + span >= PB) begin
            pos <= '0;
            if (second) begin
              status <= pffa_pkg::ST_NOSPACE; state <= S_OUT;
            end else state <= S_JRD;
          end else begin
            pos <= pos + span; state <= S_FRD;
          end
        end
        S_JRD: state <= S_JCHK;
        S_JCHK: begin
          if (h[0]) begin
            if (pos + span >= PB) begin
              pos <= '0; second <= 1'b1; state <= S_FRD;
            end else begin
              pos <= pos + span; state <= S_JRD;
            end
          end else begin
            hacc <= h; nxt <= pos + h + PW'(4);
            state <= (pos + h + PW'(4) < PB) ? S_NRD : S_NCHK;
          end
        end
        S_NRD: state <= S_NCHK;
        S_NCHK: begin
          // rdata valid only when nxt is inside the page
          if (nxt < PB && !h[0]) begin
            hacc <= hacc + h + PW'(4); nxt <= pos + hacc + h + PW'(8);
            state <= (pos + hacc + h + PW'(8) < PB) ? S_NRD : S_NCHK;
          end else if (nxt >= PB) begin
            pos <= '0; second <= 1'b1; state <= S_FRD;
          end else begin
            pos <= nxt; state <= S_JRD;
          end
        end
        S_SPLIT: begin
          nxt <= pos + need + PW'(4); state <= S_DONE;
        end
        S_DONE: begin
          fcount <= (fcount > need + PW'(4)) ? fcount - need - PW'(4) : '0;
          uoff <= 12'(pos + PW'(4)); state <= S_OUT;
        end
        S_RRD: begin
          if (rel < PW'(4) || rel >= PB) begin
            status <= pffa_pkg::ST_BADOFF; state <= S_OUT;
          end else state <= S_RCHK;
        end
        S_RCHK: begin
          if (pos == rel - PW'(4)) begin
            if (!h[0]) status <= pffa_pkg::ST_NOTUSED;
            else fcount <= (fcount + h + PW'(3) > PB) ? PB : fcount + h + PW'(3);
            state <= S_OUT;
          end else if (pos > rel - PW'(4) || pos + span >= PB) begin
            status <= pffa_pkg::ST_BADOFF; state <= S_OUT;
          end else begin
            pos <= pos + span; state <= S_RRD;
          end
        end
        S_OUT: begin
          m_tvalid <= 1'b1;
          m_tdata <= {4'd0, fcount[12:0], uoff, status};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_noaccept: assert property (@(posedge clk) disable iff (rst) busy |-> !s_tready)
    else $error("accepted during clearing");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> m_tvalid) else $error("result lost");
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("accept with pending result");
  a_count: assert property (@(posedge clk) disable iff (rst) fcount <= PB)
    else $error("free count overflow");
endmodule

### hw/rtl/pffa_store.sv
module pffa_store (
  input  logic                    clk,
  input  logic                    rst,
  input  pffa_pkg::mem_req_t      req,
  output logic [15:0]             rdata,
  output logic                    busy
);
  logic [15:0] mem [pffa_pkg::STORE_WORDS];
  logic [pffa_pkg::AW:0] clr;

  // clearing pass after reset writes the initial page image
  assign busy = !clr[pffa_pkg::AW];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (busy) begin
      clr <= clr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr[pffa_pkg::AW-1:0]] <= (clr == '0) ? 16'(pffa_pkg::PAGE_BYTES - 4) : 16'd0;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule

### tb/sv/page_first_fit_allocator_unit_tb.sv
module page_first_fit_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pffa_pkg::*;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam int RANDOM_ITEMS = 1880;
  localparam int CYCLE_LIMIT = 40_000_000;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] user_offset;
    logic [12:0] bytes_free;
  } alloc_result_t;

  typedef struct {
    logic          op;
    logic [12:0]   req;
    logic [11:0]   rel;
    bit            typed;
    alloc_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  logic [15:0]   shadow_page [STORE_WORDS];
  int unsigned   shadow_free;
  alloc_result_t expected_results [$];
  stim_row_t     stim_table [$];
  logic [11:0]   live_offsets [$];
  int            error_count = 0;
  int unsigned   cycle_count = 0;
  int            burst_left = 0;

  page_first_fit_allocator_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned hdr_read(int unsigned pos);
    return ((pos >> 1) < STORE_WORDS) ? int'(shadow_page[pos >> 1]) : 0;
  endfunction

  function automatic void hdr_write(int unsigned pos, int unsigned v);
    if ((pos >> 1) < STORE_WORDS) shadow_page[pos >> 1] = v[15:0];
  endfunction

  function automatic bit find_first_fit(int unsigned need, output int unsigned where);
    int unsigned pos;
    int unsigned h;
    pos = 0;
    where = 0;
    while (pos < PAGE_BYTES) begin
      h = hdr_read(pos);
      if (!h[0] && h >= need) begin
        where = pos;
        return 1'b1;
      end
      pos += (h & ~32'd1) + 4;
    end
    return 1'b0;
  endfunction

  function automatic void merge_free_runs();
    int unsigned pos;
    int unsigned h;
    int unsigned nxt;
    pos = 0;
    while (pos < PAGE_BYTES) begin
      h = hdr_read(pos);
      if (h[0]) begin
        pos += (h & ~32'd1) + 4;
      end else begin
        nxt = pos + h + 4;
        while (nxt < PAGE_BYTES && (hdr_read(nxt) & 32'd1) == 0) begin
          h += hdr_read(nxt) + 4;
          nxt = pos + h + 4;
        end
        hdr_write(pos, h);
        pos = nxt;
      end
    end
  endfunction

  function automatic bit on_block_chain(int unsigned target);
    int unsigned pos;
    pos = 0;
    while (pos < PAGE_BYTES) begin
      if (pos == target) return 1'b1;
      if (pos > target) return 1'b0;
      pos += (hdr_read(pos) & ~32'd1) + 4;
    end
    return 1'b0;
  endfunction

  function automatic alloc_result_t predict_page_op(logic op, logic [12:0] req,
                                                    logic [11:0] rel);
    alloc_result_t r;
    int unsigned n;
    int unsigned ov;
    int unsigned where;
    int unsigned total;
    int unsigned h;
    bit found;
    r.status = ST_OK;
    r.user_offset = '0;
    if (op == OP_ALLOC) begin
      if (req == 0 || req > PAGE_BYTES) begin
        r.status = ST_INVALID;
      end else begin
        n = req + req[0];
        if (n + 4 > PAGE_BYTES) begin
          ov = (n + 4) % PAGE_BYTES;
          if (ov > 0 && ov < 5) n += 4;
        end
        found = find_first_fit(n, where);
        if (!found) begin
          merge_free_runs();
          found = find_first_fit(n, where);
        end
        if (!found) begin
          r.status = ST_NOSPACE;
        end else begin
          total = hdr_read(where);
          if (total >= n + 4) begin
            hdr_write(where + 4 + n, total - (n + 4));
            hdr_write(where, n + 1);
          end else begin
            hdr_write(where, total + 1);
          end
          shadow_free = (shadow_free > n + 4) ? shadow_free - (n + 4) : 0;
          r.user_offset = 12'(where + 4);
        end
      end
    end else begin
      if (rel < 4 || !on_block_chain(rel - 4)) begin
        r.status = ST_BADOFF;
      end else begin
        h = hdr_read(rel - 4);
        if (!h[0]) begin
          r.status = ST_NOTUSED;
        end else begin
          h -= 1;
          hdr_write(rel - 4, h);
          shadow_free += h + 4;
          if (shadow_free > PAGE_BYTES) shadow_free = PAGE_BYTES;
        end
      end
    end
    r.bytes_free = 13'(shadow_free);
    return r;
  endfunction

  function automatic void add_row(logic op, logic [12:0] req, logic [11:0] rel, bit typed,
                                  logic [2:0] st, logic [11:0] uo, logic [12:0] bf);
    stim_row_t row;
    row.op = op;
    row.req = req;
    row.rel = rel;
    row.typed = typed;
    row.res.status = st;
    row.res.user_offset = uo;
    row.res.bytes_free = bf;
    stim_table.push_back(row);
  endfunction

  // bursts of transfers with random gaps, then prediction on acceptance
  task automatic send_item(logic op, logic [12:0] req, logic [11:0] rel, bit typed,
                           alloc_result_t typed_res);
    alloc_result_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, rel, req, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_page_op(op, req, rel);
    expected_results.push_back(typed ? typed_res : r);
    if (op == OP_ALLOC && r.status == ST_OK) live_offsets.push_back(r.user_offset);
  endtask

  // receiver stall pattern: character picked by bits 8:7 of the cycle counter
  always @(posedge clk) begin
    case ((cycle_count >> 7) % 4)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      2: m_tready <= (cycle_count[2:0] != 3'd0);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[2:0];
      got.user_offset = m_tdata[14:3];
      got.bytes_free = m_tdata[27:15];
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: %h", m_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.user_offset != want.user_offset) begin
          $error("user_offset: expected %0d, got %0d", want.user_offset, got.user_offset);
          error_count++;
        end
        if (got.bytes_free != want.bytes_free) begin
          $error("bytes_free: expected %0d, got %0d", want.bytes_free, got.bytes_free);
          error_count++;
        end
      end
    end
  end

  initial begin
    int k;
    int pick;
    int sel;
    logic op;
    logic [12:0] req;
    logic [11:0] rel;
    alloc_result_t none;
    none = '0;
    for (k = 0; k < STORE_WORDS; k++) shadow_page[k] = '0;
    shadow_page[0] = 16'(PAGE_BYTES - 4);
    shadow_free = PAGE_BYTES;

    // zero and oversized requests, large requests padded past the page, bad offsets
    add_row(OP_ALLOC, 13'd0,    12'd0,    1, ST_INVALID, 12'd0, 13'd4096);
    add_row(OP_ALLOC, 13'd4097, 12'd0,    1, ST_INVALID, 12'd0, 13'd4096);
    add_row(OP_ALLOC, 13'h1FFF, 12'hFFF,  1, ST_INVALID, 12'd0, 13'd4096);
    add_row(OP_ALLOC, 13'd4096, 12'd0,    1, ST_NOSPACE, 12'd0, 13'd4096);
    add_row(OP_ALLOC, 13'd4093, 12'd0,    1, ST_NOSPACE, 12'd0, 13'd4096);
    add_row(OP_FREE,  13'd0,    12'd0,    1, ST_BADOFF,  12'd0, 13'd4096);
    add_row(OP_FREE,  13'd0,    12'd3,    1, ST_BADOFF,  12'd0, 13'd4096);
    add_row(OP_FREE,  13'h1FFF, 12'hFFF,  1, ST_BADOFF,  12'd0, 13'd4096);
    add_row(OP_FREE,  13'd0,    12'd4,    1, ST_NOTUSED, 12'd0, 13'd4096);
    add_row(OP_ALLOC, 13'd1,    12'd0,    1, ST_OK,      12'd4, 13'd4090);
    add_row(OP_FREE,  13'd0,    12'd4,    1, ST_OK,      12'd0, 13'd4096);
    // whole page after a join, then full
    add_row(OP_ALLOC, 13'd4092, 12'd0,    1, ST_OK,      12'd4, 13'd0);
    add_row(OP_ALLOC, 13'd2,    12'd0,    1, ST_NOSPACE, 12'd0, 13'd0);
    add_row(OP_FREE,  13'd0,    12'd4,    1, ST_OK,      12'd0, 13'd4096);
    // zero-byte leftover, tight fit and odd sizes
    add_row(OP_ALLOC, 13'd4088, 12'd0,    0, ST_OK, 12'd0, 13'd0);
    add_row(OP_ALLOC, 13'd1,    12'd0,    0, ST_OK, 12'd0, 13'd0);
    add_row(OP_FREE,  13'd0,    12'd4,    0, ST_OK, 12'd0, 13'd0);
    add_row(OP_ALLOC, 13'd99,   12'd0,    0, ST_OK, 12'd0, 13'd0);
    add_row(OP_ALLOC, 13'd100,  12'd0,    0, ST_OK, 12'd0, 13'd0);
    add_row(OP_FREE,  13'd0,    12'd4,    0, ST_OK, 12'd0, 13'd0);
    add_row(OP_ALLOC, 13'd98,   12'd0,    0, ST_OK, 12'd0, 13'd0);
    add_row(OP_FREE,  13'd0,    12'd106,  0, ST_OK, 12'd0, 13'd0);
    add_row(OP_FREE,  13'd0,    12'd106,  0, ST_OK, 12'd0, 13'd0);
    add_row(OP_FREE,  13'd0,    12'd4,    0, ST_OK, 12'd0, 13'd0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i])
      send_item(stim_table[i].op, stim_table[i].req, stim_table[i].rel,
                stim_table[i].typed, stim_table[i].res);
    live_offsets.delete();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      sel = $urandom_range(0, 99);
      if (live_offsets.size() > 40) sel = (sel < 50) ? 60 : sel;
      req = '0;
      rel = '0;
      if (sel < 50) begin
        op = OP_ALLOC;
        req = ($urandom_range(0, 19) == 0) ? 13'($urandom_range(1, 4096))
                                           : 13'($urandom_range(1, 300));
        rel = 12'($urandom);
      end else if (sel < 85 && live_offsets.size() > 0) begin
        op = OP_FREE;
        pick = $urandom_range(0, live_offsets.size() - 1);
        rel = live_offsets[pick];
        live_offsets.delete(pick);
        req = 13'($urandom);
      end else begin
        // noise: random bits everywhere, stray and repeated frees
        op = 1'($urandom);
        req = 13'($urandom);
        rel = 12'($urandom);
      end
      send_item(op, req, rel, 1'b0, none);
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/pffa_pkg.sv
hw/rtl/pffa_store.sv
hw/rtl/page_first_fit_allocator_unit.sv
tb/sv/page_first_fit_allocator_unit_tb.sv
